### hdl/tga_rle_scanline_encoder_macros.svh
// ----------------------------------------------------------------------------
// TGA RLE encoder assertion macros
// Shared concurrent assertion forms for the encoder blocks.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_SCANLINE_ENCODER_MACROS_SVH
`define TGA_RLE_SCANLINE_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TRSE_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TRSE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/trse_pkg.sv
// ----------------------------------------------------------------------------
// TGA RLE encoder package
// Constants, controller states and the command/status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package trse_pkg;

  // Default longest packet in pixels
  localparam int MAX_PACKET_DEF = 32;

  // Pixel size register
  localparam logic [2:0] BPP_RESET = 3'd4;
  localparam logic [2:0] BPP_24    = 3'd3;

  // Header fields and pixel masks
  localparam logic [7:0]  REPEAT_FLAG = 8'd128;
  localparam logic [7:0]  COUNT_MASK  = 8'd127;
  localparam logic [31:0] PIX_MASK_24 = 32'h00FF_FFFF;
  localparam logic [31:0] PIX_MASK_32 = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EQ_INC,
    ST_NEW_RUN,
    ST_LAST_CHK,
    ST_FLUSH,
    ST_REP,
    ST_RAW_RD,
    ST_RAW_EMIT,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;    // capture the accepted word
    logic set_new;    // start a new run with the captured pixel
    logic inc_rc;     // extend the pending run
    logic push;       // move the pending pixel into the raw store
    logic emit_rep;   // emit a repeat packet
    logic raw_start;  // begin reading the raw store at entry zero
    logic raw_emit;   // emit the current raw entry
    logic finish;     // release the held result as the item's last
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic eq;           // captured pixel matches the pending run
    logic rc_one;
    logic rc_ge2;
    logic dc_zero;
    logic dc_full_next; // raw store is full after one more push
    logic rc_full_next; // run is full after one more increment
    logic last_in;
    logic can_emit;     // output register can take a word this cycle
    logic raw_last;     // current raw entry is the final one
    logic hold_valid;
  } stat_t;

endpackage

### hdl/trse_ctrl.sv
// ----------------------------------------------------------------------------
// TGA RLE encoder controller
// Steps one pixel through the run decision and sequences packet emission.
// ----------------------------------------------------------------------------
module trse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  trse_pkg::stat_t  stat,
  output trse_pkg::cmd_t   cmd
);

  trse_pkg::state_t state, state_next;
  trse_pkg::state_t ret, ret_next;

  // State and return registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trse_pkg::ST_IDLE;
      ret   <= trse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  assign in_stall = (state != trse_pkg::ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '0;
    unique case (state)
      trse_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = trse_pkg::ST_EVAL;
        end
      end
      trse_pkg::ST_EVAL: begin
        if (stat.eq) begin
          if (stat.rc_one && !stat.dc_zero) begin
            ret_next   = trse_pkg::ST_EQ_INC;
            state_next = trse_pkg::ST_RAW_RD;
          end else begin
            state_next = trse_pkg::ST_EQ_INC;
          end
        end else if (stat.rc_ge2) begin
          ret_next   = trse_pkg::ST_NEW_RUN;
          state_next = trse_pkg::ST_REP;
        end else if (stat.rc_one) begin
          cmd.push = 1'b1;
          if (stat.dc_full_next) begin
            ret_next   = trse_pkg::ST_NEW_RUN;
            state_next = trse_pkg::ST_RAW_RD;
          end else begin
            state_next = trse_pkg::ST_NEW_RUN;
          end
        end else begin
          state_next = trse_pkg::ST_NEW_RUN;
        end
      end
      trse_pkg::ST_EQ_INC: begin
        cmd.inc_rc = 1'b1;
        if (stat.rc_full_next) begin
          ret_next   = trse_pkg::ST_LAST_CHK;
          state_next = trse_pkg::ST_REP;
        end else begin
          state_next = trse_pkg::ST_LAST_CHK;
        end
      end
      trse_pkg::ST_NEW_RUN: begin
        cmd.set_new = 1'b1;
        state_next  = trse_pkg::ST_LAST_CHK;
      end
      trse_pkg::ST_LAST_CHK: begin
        if (!stat.last_in) begin
          state_next = trse_pkg::ST_FIN;
        end else if (stat.rc_ge2) begin
          ret_next   = trse_pkg::ST_FLUSH;
          state_next = trse_pkg::ST_REP;
        end else begin
          cmd.push   = stat.rc_one;
          state_next = trse_pkg::ST_FLUSH;
        end
      end
      trse_pkg::ST_FLUSH: begin
        if (!stat.dc_zero) begin
          ret_next   = trse_pkg::ST_FIN;
          state_next = trse_pkg::ST_RAW_RD;
        end else begin
          state_next = trse_pkg::ST_FIN;
        end
      end
      trse_pkg::ST_REP: begin
        if (stat.can_emit) begin
          cmd.emit_rep = 1'b1;
          state_next   = ret;
        end
      end
      trse_pkg::ST_RAW_RD: begin
        cmd.raw_start = 1'b1;
        state_next    = trse_pkg::ST_RAW_EMIT;
      end
      trse_pkg::ST_RAW_EMIT: begin
        if (stat.can_emit) begin
          cmd.raw_emit = 1'b1;
          if (stat.raw_last) begin
            state_next = ret;
          end
        end
      end
      trse_pkg::ST_FIN: begin
        if (!stat.hold_valid) begin
          state_next = trse_pkg::ST_IDLE;
        end else if (stat.can_emit) begin
          cmd.finish = 1'b1;
          state_next = trse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = trse_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/trse_datapath.sv
// ----------------------------------------------------------------------------
// TGA RLE encoder datapath
// Run and raw counters, the raw pixel store, a one-word hold stage that
// tags the item's last result, and the output register.
// ----------------------------------------------------------------------------
`include "tga_rle_scanline_encoder_macros.svh"

module trse_datapath #(
  parameter int MAX_PACKET = trse_pkg::MAX_PACKET_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       bytes_per_pixel,
  input  logic [31:0]      pixel_value,
  input  logic             line_end,
  input  trse_pkg::cmd_t   cmd,
  output trse_pkg::stat_t  stat,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             header_valid,
  output logic [7:0]       header_byte,
  output logic [31:0]      out_pixel,
  output logic             run_last
);

  localparam int IW = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
  localparam int CW = $clog2(MAX_PACKET + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_PACKET);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [2:0]    bpp;
  logic [31:0]   pix_in;
  logic          last_in;
  logic [31:0]   prev;
  logic [CW-1:0] rc;
  logic [CW-1:0] dc;
  logic [IW-1:0] idx;
  logic [IW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic [31:0]   mem [MAX_PACKET];

  logic          hold_valid;
  logic          hold_hv;
  logic [7:0]    hold_hb;
  logic [31:0]   hold_pix;

  logic [31:0]   mask;
  logic          emit;
  logic          new_hv;
  logic [7:0]    new_hb;
  logic [31:0]   new_pix;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] rc_p1;
  logic [CW-1:0] dc_p1;
  logic          can_emit;

  assign mask   = (bpp == trse_pkg::BPP_24) ? trse_pkg::PIX_MASK_24 : trse_pkg::PIX_MASK_32;
  assign idx_p1 = CW'(idx) + ONE_C;
  assign rc_p1  = rc + ONE_C;
  assign dc_p1  = dc + ONE_C;
  assign can_emit = !out_valid || !out_stall;

  // Status toward the controller
  always_comb begin
    stat.eq           = (rc != '0) && (((pix_in ^ prev) & mask) == 32'd0);
    stat.rc_one       = (rc == ONE_C);
    stat.rc_ge2       = (rc > ONE_C);
    stat.dc_zero      = (dc == '0);
    stat.dc_full_next = (dc_p1 >= MAX_C);
    stat.rc_full_next = (rc_p1 >= MAX_C);
    stat.last_in      = last_in;
    stat.can_emit     = can_emit;
    stat.raw_last     = (idx_p1 == dc);
    stat.hold_valid   = hold_valid;
  end

  // Pixel size register
  always_ff @(posedge clk) begin
    if (rst) begin
      bpp <= trse_pkg::BPP_RESET;
    end else if (cfg_write) begin
      bpp <= bytes_per_pixel;
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pix_in  <= pixel_value;
      last_in <= line_end;
    end
  end

  // Run and raw counters, pending pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      rc <= '0;
      dc <= '0;
    end else begin
      if (cmd.set_new) begin
        rc <= ONE_C;
      end else if (cmd.inc_rc) begin
        rc <= rc_p1;
      end else if (cmd.push || cmd.emit_rep) begin
        rc <= '0;
      end
      if (cmd.push) begin
        dc <= dc_p1;
      end else if (cmd.raw_emit && stat.raw_last) begin
        dc <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_new) begin
      prev <= pix_in;
    end
  end

  // Raw store: one write port, one registered read port
  always_comb begin
    if (cmd.raw_start) begin
      rd_addr = '0;
    end else if (cmd.raw_emit) begin
      rd_addr = idx_p1[IW-1:0];
    end else begin
      rd_addr = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[dc[IW-1:0]] <= prev;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.raw_start) begin
      idx <= '0;
    end else if (cmd.raw_emit) begin
      idx <= idx_p1[IW-1:0];
    end
  end

  // Build the next result word
  assign emit = cmd.emit_rep || cmd.raw_emit;

  always_comb begin
    if (cmd.emit_rep) begin
      new_hv  = 1'b1;
      new_hb  = trse_pkg::REPEAT_FLAG | ((8'(rc) - 8'd1) & trse_pkg::COUNT_MASK);
      new_pix = prev & mask;
    end else begin
      new_hv  = (idx == '0);
      new_hb  = (idx == '0) ? ((8'(dc) - 8'd1) & trse_pkg::COUNT_MASK) : 8'd0;
      new_pix = rd_data & mask;
    end
  end

  // Hold the newest result until it is known whether another follows
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (emit) begin
      hold_valid <= 1'b1;
    end else if (cmd.finish) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hold_hv  <= new_hv;
      hold_hb  <= new_hb;
      hold_pix <= new_pix;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((emit && hold_valid) || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((emit && hold_valid) || cmd.finish) begin
      header_valid <= hold_hv;
      header_byte  <= hold_hb;
      out_pixel    <= hold_pix;
      run_last     <= cmd.finish;
    end
  end

  `TRSE_ASSERT_IMPL(a_rep_count, clk, rst, cmd.emit_rep, rc > ONE_C, "repeat packet shorter than two")
  `TRSE_ASSERT_IMPL(a_raw_range, clk, rst, cmd.raw_emit, (dc != '0) && (CW'(idx) < dc), "raw read outside the filled entries")
  `TRSE_ASSERT_NEXT(a_finish, clk, rst, cmd.finish, !hold_valid && out_valid, "last result not released")

endmodule

### hdl/tga_rle_scanline_encoder.sv
// ----------------------------------------------------------------------------
// TGA RLE scanline encoder
// Turns a pixel stream into TGA repeat and raw packets, one pixel per word.
// ----------------------------------------------------------------------------
// One pixel is in work at a time: in_stall stays high from the accept until
// the controller is idle again, longer when the pixel closes a packet, at a
// line end or on output stalls; raw packets need a store read setup first.
// A word waits in a one-word hold stage until the next word or the item's end
// releases it; the last word reaches the output as the controller goes idle.
// Reset (rst, synchronous) empties all runs and selects 32-bit pixels.
// ----------------------------------------------------------------------------
module tga_rle_scanline_encoder #(
  parameter int MAX_PACKET = trse_pkg::MAX_PACKET_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  bytes_per_pixel,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] pixel_value,
  input  logic        line_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        header_valid,
  output logic [7:0]  header_byte,
  output logic [31:0] out_pixel,
  output logic        run_last
);

  trse_pkg::cmd_t  cmd;
  trse_pkg::stat_t stat;

  // Register writes must arrive only while idle; the block itself does not enforce it
  assign cfg_ready = 1'b1;

  trse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  trse_datapath #(
    .MAX_PACKET (MAX_PACKET)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_valid && cfg_ready),
    .bytes_per_pixel (bytes_per_pixel),
    .pixel_value     (pixel_value),
    .line_end        (line_end),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .header_valid    (header_valid),
    .header_byte     (header_byte),
    .out_pixel       (out_pixel),
    .run_last        (run_last)
  );

endmodule
